>>> rtl/core/uart_rm_pkg.sv
// ----------------------------------------------------------------------------
// uart_rm_pkg
// Shared types, register offsets and helper functions for the UART register
// model block.
// ----------------------------------------------------------------------------
package uart_rm_pkg;

  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IDLE_W     = CFG_DATA_W + 2;

  // bus operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // register offsets inside the span
  localparam logic [REG_IDX_W-1:0] REG_RBR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IIR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LCR = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MCR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LSR = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MSR = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCR = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_CYCLES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_IVAL   = 1'd1;

  localparam logic [7:0] MSR_RESET   = 8'hb0;
  localparam logic [7:0] FCR_MASK    = 8'hc9;
  localparam logic [3:0] DELTA_MASK  = 4'hb;
  localparam logic [3:0] IIR_ID_THRE = 4'h2;
  localparam logic [7:0] IIR_FIFO_ON = 8'hc0;
  localparam logic [7:0] IIR_OVERRUN = 8'h06;
  localparam logic [7:0] IIR_RX_DATA = 8'h04;
  localparam logic [7:0] IIR_TIMEOUT = 8'h0c;
  localparam logic [7:0] IIR_THRE    = 8'h02;
  localparam logic [7:0] IIR_MODEM   = 8'h00;
  localparam logic [7:0] IIR_NONE    = 8'h01;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic       host_byte_valid;
    logic [7:0] host_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       response;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       host_byte_taken;
    logic       irq;
  } result_t;

  function automatic logic [CNT_W-1:0] rx_capacity(input logic [7:0] fcr);
    return fcr[0] ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] trig_level(input logic [7:0] fcr);
    logic [CNT_W-1:0] lvl;
    unique case (fcr[7:6])
      2'd0: lvl = CNT_W'(1);
      2'd1: lvl = CNT_W'(4);
      2'd2: lvl = CNT_W'(8);
      2'd3: lvl = CNT_W'(14);
    endcase
    return fcr[0] ? lvl : CNT_W'(1);
  endfunction

  // interrupt identification in priority order
  function automatic logic [7:0] iir_calc(
    input logic [7:0]       fcr,
    input logic [3:0]       ier,
    input logic             ovr,
    input logic [CNT_W-1:0] cnt,
    input logic             tmo,
    input logic             thre,
    input logic [3:0]       md
  );
    logic [7:0] fb;
    logic [7:0] id;
    fb = fcr[0] ? IIR_FIFO_ON : 8'h00;
    priority if (ier[2] && ovr) begin
      id = IIR_OVERRUN;
    end else if (ier[0] && cnt >= trig_level(fcr)) begin
      id = IIR_RX_DATA;
    end else if (ier[0] && cnt != '0 && fcr[0] && tmo) begin
      id = IIR_TIMEOUT;
    end else if (ier[1] && thre) begin
      id = IIR_THRE;
    end else if (ier[3] && md != 4'h0) begin
      id = IIR_MODEM;
    end else begin
      id = IIR_NONE;
    end
    return fb | id;
  endfunction

endpackage

>>> rtl/core/uart_rm_core.sv
// ----------------------------------------------------------------------------
// uart_rm_core
// Register state of the UART model and the combinational update for one
// registered bus event; produces the result for the output register.
// ----------------------------------------------------------------------------
module uart_rm_core
  import uart_rm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  item_t                 item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  logic [7:0]            rx_store [FIFO_DEPTH];
  logic [PTR_W-1:0]      rx_head, rx_head_next;
  logic [CNT_W-1:0]      rx_count, rx_count_next;
  logic [7:0]            divisor_low, divisor_low_next;
  logic [7:0]            divisor_high, divisor_high_next;
  logic [3:0]            int_enable, int_enable_next;
  logic [7:0]            line_ctrl, line_ctrl_next;
  logic [4:0]            modem_ctrl, modem_ctrl_next;
  logic [7:0]            fifo_ctrl, fifo_ctrl_next;
  logic [7:0]            scratch_reg, scratch_reg_next;
  logic [IDLE_W-1:0]     idle_timer, idle_timer_next;
  logic [CFG_DATA_W-1:0] poll_countdown, poll_countdown_next;
  logic                  thre_flag, thre_flag_next;
  logic                  tx_busy, tx_busy_next;
  logic                  overrun_flag, overrun_flag_next;
  logic [7:0]            modem_stat, modem_stat_next;
  logic [3:0]            modem_deltas, modem_deltas_next;
  logic                  irq_line, irq_line_next;
  logic [CFG_DATA_W-1:0] char_cycles;
  logic [CFG_DATA_W-1:0] poll_interval;

  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [7:0]            wr_data;
  logic [IDLE_W-1:0]     tmo_limit;
  logic [7:0]            iir_v;
  logic [7:0]            iir_after;
  logic [3:0]            chg;
  logic                  in_span;
  logic [REG_IDX_W-1:0]  ridx;

  assign tmo_limit = {char_cycles, 2'b00};
  assign in_span   = !item.reg_offset[3];
  assign ridx      = item.reg_offset[REG_IDX_W-1:0];

  always_comb begin
    rx_head_next        = rx_head;
    rx_count_next       = rx_count;
    divisor_low_next    = divisor_low;
    divisor_high_next   = divisor_high;
    int_enable_next     = int_enable;
    line_ctrl_next      = line_ctrl;
    modem_ctrl_next     = modem_ctrl;
    fifo_ctrl_next      = fifo_ctrl;
    scratch_reg_next    = scratch_reg;
    idle_timer_next     = idle_timer;
    poll_countdown_next = poll_countdown;
    thre_flag_next      = thre_flag;
    tx_busy_next        = tx_busy;
    overrun_flag_next   = overrun_flag;
    modem_stat_next     = modem_stat;
    modem_deltas_next   = modem_deltas;
    irq_line_next       = irq_line;
    wr_en               = 1'b0;
    wr_addr             = '0;
    wr_data             = '0;
    iir_v               = '0;
    chg                 = '0;
    result              = '0;

    if (item.operation == OP_TICK) begin
      if (poll_countdown_next != '0) poll_countdown_next = poll_countdown_next - 1'b1;
      if (tx_busy_next) begin
        tx_busy_next   = 1'b0;
        thre_flag_next = 1'b1;
      end
      if (rx_count_next != '0 && idle_timer_next < tmo_limit)
        idle_timer_next = idle_timer_next + 1'b1;
    end

    // host source poll on ticks and in-span reads
    if ((item.operation == OP_TICK || (item.operation == OP_READ && in_span)) &&
        !modem_ctrl_next[4] && poll_countdown_next == '0) begin
      if (rx_count_next < rx_capacity(fifo_ctrl_next) && item.host_byte_valid) begin
        wr_en                  = 1'b1;
        wr_addr                = rx_head_next + rx_count_next[PTR_W-1:0];
        wr_data                = item.host_byte;
        rx_count_next          = rx_count_next + 1'b1;
        idle_timer_next        = '0;
        result.host_byte_taken = 1'b1;
      end
      if (rx_count_next < rx_capacity(fifo_ctrl_next))
        poll_countdown_next = (poll_interval == CFG_DATA_W'(1)) ? '0 : poll_interval;
    end

    if ((item.operation == OP_READ || item.operation == OP_WRITE) && !in_span) begin
      result.response = 1'b1;
    end else if (item.operation == OP_READ) begin
      unique case (ridx)
        REG_RBR: begin
          if (line_ctrl_next[7]) begin
            result.read_data = divisor_low_next;
          end else if (rx_count_next != '0) begin
            // a byte pushed into an empty fifo this cycle is not stored yet
            result.read_data = (rx_count == '0) ? wr_data : rx_store[rx_head_next];
            rx_head_next     = rx_head_next + 1'b1;
            rx_count_next    = rx_count_next - 1'b1;
            idle_timer_next  = '0;
          end
        end
        REG_IER: result.read_data = line_ctrl_next[7] ? divisor_high_next
                                                      : {4'h0, int_enable_next};
        REG_IIR: begin
          iir_v = iir_calc(fifo_ctrl_next, int_enable_next, overrun_flag_next,
                           rx_count_next, idle_timer_next >= tmo_limit,
                           thre_flag_next, modem_deltas_next);
          if (iir_v[3:0] == IIR_ID_THRE) thre_flag_next = 1'b0;
          result.read_data = iir_v;
        end
        REG_LCR: result.read_data = line_ctrl_next;
        REG_MCR: result.read_data = {3'b000, modem_ctrl_next};
        REG_LSR: begin
          result.read_data = {1'b0, {2{!tx_busy_next}}, 3'b000, overrun_flag_next,
                              rx_count_next != '0};
          overrun_flag_next = 1'b0;
        end
        REG_MSR: begin
          result.read_data  = modem_stat_next | {4'h0, modem_deltas_next};
          modem_deltas_next = '0;
        end
        REG_SCR: result.read_data = scratch_reg_next;
      endcase
    end else if (item.operation == OP_WRITE) begin
      unique case (ridx)
        REG_RBR: begin
          if (line_ctrl[7]) begin
            divisor_low_next = item.write_data;
          end else begin
            thre_flag_next = 1'b0;
            tx_busy_next   = 1'b1;
            if (modem_ctrl[4]) begin
              // loopback: transmitted byte lands in the receive fifo
              if (rx_count >= rx_capacity(fifo_ctrl)) begin
                overrun_flag_next = 1'b1;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = rx_head + rx_count[PTR_W-1:0];
                wr_data       = item.write_data;
                rx_count_next = rx_count + 1'b1;
              end
              idle_timer_next = '0;
            end else begin
              result.tx_valid = 1'b1;
              result.tx_byte  = item.write_data;
            end
          end
        end
        REG_IER: begin
          if (line_ctrl[7]) begin
            divisor_high_next = item.write_data;
          end else begin
            if (item.write_data[1] && !int_enable[1] && !tx_busy) thre_flag_next = 1'b1;
            int_enable_next = item.write_data[3:0];
          end
        end
        REG_IIR: begin
          if (item.write_data[1] || (item.write_data[0] ^ fifo_ctrl[0])) begin
            rx_count_next   = '0;
            rx_head_next    = '0;
            idle_timer_next = '0;
          end
          if (item.write_data[2]) begin
            tx_busy_next   = 1'b0;
            thre_flag_next = 1'b1;
          end
          fifo_ctrl_next = item.write_data & FCR_MASK;
        end
        REG_LCR: line_ctrl_next = item.write_data;
        REG_MCR: begin
          modem_ctrl_next = item.write_data[4:0];
          modem_stat_next = item.write_data[4]
                          ? {item.write_data[3], item.write_data[2], item.write_data[0],
                             item.write_data[1], 4'h0}
                          : MSR_RESET;
          chg = modem_stat[7:4] ^ modem_stat_next[7:4];
          modem_deltas_next = modem_deltas | (chg & DELTA_MASK) |
                              ((modem_stat[6] && !modem_stat_next[6]) ? 4'h4 : 4'h0);
        end
        REG_LSR, REG_MSR: ;
        REG_SCR: scratch_reg_next = item.write_data;
      endcase
    end

    iir_after = iir_calc(fifo_ctrl_next, int_enable_next, overrun_flag_next,
                         rx_count_next, idle_timer_next >= tmo_limit,
                         thre_flag_next, modem_deltas_next);
    if (item.operation == OP_TICK ||
        ((item.operation == OP_READ || item.operation == OP_WRITE) && in_span)) begin
      irq_line_next = !iir_after[0];
    end
    result.irq = irq_line_next;
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      rx_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head        <= '0;
      rx_count       <= '0;
      divisor_low    <= '0;
      divisor_high   <= '0;
      int_enable     <= '0;
      line_ctrl      <= '0;
      modem_ctrl     <= '0;
      fifo_ctrl      <= '0;
      scratch_reg    <= '0;
      idle_timer     <= '0;
      poll_countdown <= '0;
      thre_flag      <= 1'b1;
      tx_busy        <= 1'b0;
      overrun_flag   <= 1'b0;
      modem_stat     <= MSR_RESET;
      modem_deltas   <= '0;
      irq_line       <= 1'b0;
      char_cycles    <= CFG_DATA_W'(1);
      poll_interval  <= CFG_DATA_W'(1);
    end else begin
      if (step) begin
        rx_head        <= rx_head_next;
        rx_count       <= rx_count_next;
        divisor_low    <= divisor_low_next;
        divisor_high   <= divisor_high_next;
        int_enable     <= int_enable_next;
        line_ctrl      <= line_ctrl_next;
        modem_ctrl     <= modem_ctrl_next;
        fifo_ctrl      <= fifo_ctrl_next;
        scratch_reg    <= scratch_reg_next;
        idle_timer     <= idle_timer_next;
        thre_flag      <= thre_flag_next;
        tx_busy        <= tx_busy_next;
        overrun_flag   <= overrun_flag_next;
        modem_stat     <= modem_stat_next;
        modem_deltas   <= modem_deltas_next;
        irq_line       <= irq_line_next;
      end
      // a poll interval write clears the countdown
      if (cfg_write && cfg_index == CFG_POLL_IVAL) begin
        poll_countdown <= '0;
      end else if (step) begin
        poll_countdown <= poll_countdown_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_CHAR_CYCLES: char_cycles <= cfg_data;
          CFG_POLL_IVAL:   poll_interval <= cfg_data;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CNT_W'(FIFO_DEPTH))
    else $error("receive count beyond fifo depth");

  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    !fifo_ctrl[0] |-> rx_count <= CNT_W'(1))
    else $error("non-fifo mode holds more than one byte");

  a_thre_busy: assert property (@(posedge clk) disable iff (rst)
    !(tx_busy && thre_flag))
    else $error("thre set while transmitter busy");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    step && item.reg_offset[3] && item.operation != OP_TICK
    |=> $stable(rx_count) && $stable(irq_line))
    else $error("out-of-span access changed state");
`endif

endmodule

>>> rtl/core/uart_register_model_top.sv
// ----------------------------------------------------------------------------
// uart_register_model_top
// 16550-style UART register block, one bus event per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries a tick, a register read
//   or a register write together with an optional byte from the host source.
//   result channel (result_valid/result_ready/result) returns one result per
//   item: read data, response, transmitted byte, host byte taken and irq.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets character
//   cycles (index 0) and the host poll interval (index 1); always ready.
//   The item is held in an input register; its whole update runs when the
//   result register is free or being taken and lands in the result register.
//   One item per cycle is sustained while the result side does not stall.
//   When the result side stalls, the result register holds and the input
//   register takes one more item; item_ready then drops until the result
//   moves on.
//   Reset clears both pipeline registers, restores register reset values and
//   sets both configuration registers to 1. The receive store needs no clear.
// ----------------------------------------------------------------------------
module uart_register_model_top
  import uart_rm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   item_q;
  logic    item_q_valid;
  logic    step;
  result_t core_result;

  assign step       = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || step;
  assign cfg_ready  = 1'b1;

  uart_rm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item_q),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) item_q_valid <= item_valid;
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_q <= item;
    if (step) result <= core_result;
  end

endmodule

>>> tb/uart_register_model_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_register_model_top_tb
// Self-checking bench for the UART register block. A short directed pass
// walks every register, DLAB, FIFO timeout, loopback overrun and the error
// paths. Random bursts follow: host traffic, FIFO drains, register setup,
// loopback and noise, under several character and poll settings and three
// idle patterns. Each result is checked against a shadow of the registers.
// ----------------------------------------------------------------------------
module uart_register_model_top_tb;
  import uart_rm_pkg::*;

  localparam int unsigned REG_SPAN     = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam logic [1:0]  OP_NONE      = 2'd3;

  class uart_reg_scoreboard;
    int unsigned char_cycles;
    int unsigned poll_ival;
    logic [7:0]  rx_mem [FIFO_DEPTH];
    int unsigned rx_rd;
    int unsigned rx_cnt;
    logic [7:0]  dll, dlm, lcr, fcr, scr, msr;
    logic [3:0]  ier, msr_delta;
    logic [4:0]  mcr;
    int unsigned idle_cnt;
    int unsigned poll_wait;
    bit          thre, tx_busy, ovr, irq_q;
    result_t     pending_bus_results[$];
    int unsigned mismatches;

    function new();
      char_cycles = 1;
      poll_ival   = 1;
      rx_rd       = 0;
      rx_cnt      = 0;
      dll         = 8'h00;
      dlm         = 8'h00;
      lcr         = 8'h00;
      fcr         = 8'h00;
      scr         = 8'h00;
      msr         = MSR_RESET;
      ier         = 4'h0;
      msr_delta   = 4'h0;
      mcr         = 5'h00;
      idle_cnt    = 0;
      poll_wait   = 0;
      thre        = 1'b1;
      tx_busy     = 1'b0;
      ovr         = 1'b0;
      irq_q       = 1'b0;
      mismatches  = 0;
    endfunction

    function int unsigned rx_cap();
      return fcr[0] ? FIFO_DEPTH : 1;
    endfunction

    function void push_rx(logic [7:0] v);
      if (rx_cnt < FIFO_DEPTH) begin
        rx_mem[(rx_rd + rx_cnt) % FIFO_DEPTH] = v;
        rx_cnt++;
      end
    endfunction

    function logic [7:0] iir_now();
      logic [7:0]  fb;
      int unsigned trig;
      fb = fcr[0] ? IIR_FIFO_ON : 8'h00;
      case (fcr[7:6])
        2'd0: trig = 1;
        2'd1: trig = 4;
        2'd2: trig = 8;
        default: trig = 14;
      endcase
      if (!fcr[0]) trig = 1;
      if (ier[2] && ovr) return fb | IIR_OVERRUN;
      if (ier[0] && rx_cnt >= trig) return fb | IIR_RX_DATA;
      if (ier[0] && rx_cnt != 0 && fcr[0] && idle_cnt >= 4 * char_cycles)
        return fb | IIR_TIMEOUT;
      if (ier[1] && thre) return fb | IIR_THRE;
      if (ier[3] && msr_delta != 4'h0) return fb | IIR_MODEM;
      return fb | IIR_NONE;
    endfunction

    function void settle();
      logic [7:0] id;
      id = iir_now();
      irq_q = (id[0] == 1'b0);
    endfunction

    function bit poll_host(bit hv, logic [7:0] hb);
      bit taken;
      taken = 1'b0;
      if (mcr[4] || poll_wait != 0) return 1'b0;
      if (rx_cnt < rx_cap() && hv) begin
        push_rx(hb);
        idle_cnt = 0;
        taken = 1'b1;
      end
      // while the fifo has room, wait the poll interval before the next poll
      if (rx_cnt < rx_cap()) poll_wait = (poll_ival == 1) ? 0 : poll_ival;
      return taken;
    endfunction

    function logic [7:0] read_reg(logic [2:0] idx);
      logic [7:0] v;
      v = 8'h00;
      case (idx)
        REG_RBR: begin
          if (lcr[7]) begin
            v = dll;
          end else if (rx_cnt != 0) begin
            v = rx_mem[rx_rd];
            rx_rd = (rx_rd + 1) % FIFO_DEPTH;
            rx_cnt--;
            idle_cnt = 0;
          end
        end
        REG_IER: v = lcr[7] ? dlm : {4'h0, ier};
        REG_IIR: begin
          v = iir_now();
          if (v[3:0] == IIR_ID_THRE) thre = 1'b0;
        end
        REG_LCR: v = lcr;
        REG_MCR: v = {3'b000, mcr};
        REG_LSR: begin
          v = {1'b0, !tx_busy, !tx_busy, 3'b000, ovr, rx_cnt != 0};
          ovr = 1'b0;
        end
        REG_MSR: begin
          v = msr | {4'h0, msr_delta};
          msr_delta = 4'h0;
        end
        default: v = scr;
      endcase
      return v;
    endfunction

    function void set_mcr(logic [7:0] v);
      logic [7:0] prev;
      logic [3:0] chg;
      prev = msr;
      mcr = v[4:0];
      // loopback maps the outputs onto cts, dsr, ri and dcd
      msr = v[4] ? {v[3], v[2], v[0], v[1], 4'h0} : MSR_RESET;
      chg = prev[7:4] ^ msr[7:4];
      msr_delta = msr_delta | (chg & DELTA_MASK) |
                  ((prev[6] && !msr[6]) ? 4'h4 : 4'h0);
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] v,
                            output bit txv, output logic [7:0] txb);
      txv = 1'b0;
      txb = 8'h00;
      case (idx)
        REG_RBR: begin
          if (lcr[7]) begin
            dll = v;
          end else begin
            thre = 1'b0;
            tx_busy = 1'b1;
            if (mcr[4]) begin
              if (rx_cnt >= rx_cap()) ovr = 1'b1;
              else push_rx(v);
              idle_cnt = 0;
            end else begin
              txv = 1'b1;
              txb = v;
            end
          end
        end
        REG_IER: begin
          if (lcr[7]) begin
            dlm = v;
          end else begin
            if (v[1] && !ier[1] && !tx_busy) thre = 1'b1;
            ier = v[3:0];
          end
        end
        // offset 2 is fcr on a write
        REG_IIR: begin
          if (v[1] || (v[0] != fcr[0])) begin
            rx_cnt = 0;
            rx_rd = 0;
            idle_cnt = 0;
          end
          if (v[2]) begin
            tx_busy = 1'b0;
            thre = 1'b1;
          end
          fcr = v & FCR_MASK;
        end
        REG_LCR: lcr = v;
        REG_MCR: set_mcr(v);
        REG_SCR: scr = v;
        default: ;
      endcase
    endfunction

    function result_t model_bus_event(item_t it);
      result_t    r;
      bit         txv;
      logic [7:0] txb;
      r = '0;
      case (it.operation)
        OP_TICK: begin
          if (poll_wait != 0) poll_wait--;
          if (tx_busy) begin
            tx_busy = 1'b0;
            thre = 1'b1;
          end
          if (rx_cnt != 0 && idle_cnt < 4 * char_cycles) idle_cnt++;
          r.host_byte_taken = poll_host(it.host_byte_valid, it.host_byte);
          settle();
        end
        OP_READ, OP_WRITE: begin
          if (it.reg_offset >= REG_SPAN) begin
            r.response = 1'b1;
          end else if (it.operation == OP_READ) begin
            r.host_byte_taken = poll_host(it.host_byte_valid, it.host_byte);
            r.read_data = read_reg(it.reg_offset[2:0]);
            settle();
          end else begin
            write_reg(it.reg_offset[2:0], it.write_data, txv, txb);
            r.tx_valid = txv;
            r.tx_byte = txb;
            settle();
          end
        end
        default: ;
      endcase
      r.irq = irq_q;
      return r;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_CHAR_CYCLES) begin
        char_cycles = 32'(val);
      end else begin
        poll_ival = 32'(val);
        poll_wait = 0;
      end
    endfunction

    function void note_bus_item(item_t it);
      pending_bus_results.insert(pending_bus_results.size(), model_bus_event(it));
    endfunction

    function string show(result_t r);
      return $sformatf("rd=%h resp=%b txv=%b tx=%h taken=%b irq=%b",
                       r.read_data, r.response, r.tx_valid, r.tx_byte,
                       r.host_byte_taken, r.irq);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: exp %s, got %s", $time, what, show(want), show(got));
    endfunction

    function void check_bus_result(result_t got);
      result_t want;
      if (pending_bus_results.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending_bus_results[0];
      pending_bus_results.delete(0);
      if (got.read_data !== want.read_data || got.response !== want.response ||
          got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.host_byte_taken !== want.host_byte_taken || got.irq !== want.irq)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 88;
  int unsigned items_sent    = 0;
  int unsigned cycle_cnt     = 0;
  uart_reg_scoreboard uart_chk;

  uart_register_model_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) uart_chk.check_bus_result(result);
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [3:0] reg_off(input logic [REG_IDX_W-1:0] r);
    return {1'b0, r};
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    uart_chk.note_bus_item(it);
    if (it.operation == OP_TICK ||
        (it.operation != OP_NONE && it.reg_offset < REG_SPAN))
      items_sent++;
  endtask

  task automatic bus(input logic [1:0] op, input logic [3:0] off, input logic [7:0] wd,
                     input bit hv, input logic [7:0] hb);
    item_t it;
    it.operation       = op;
    it.reg_offset      = off;
    it.write_data      = wd;
    it.host_byte_valid = hv;
    it.host_byte       = hb;
    send_item(it);
  endtask

  task automatic wait_drained(input int unsigned settle_cycles);
    item_valid <= 1'b0;
    while (uart_chk.pending_bus_results.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] cc, input logic [CFG_DATA_W-1:0] pi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CHAR_CYCLES;
    cfg_data  <= cc;
    do @(posedge clk); while (!cfg_ready);
    uart_chk.note_config(CFG_CHAR_CYCLES, cc);
    cfg_index <= CFG_POLL_IVAL;
    cfg_data  <= pi;
    do @(posedge clk); while (!cfg_ready);
    uart_chk.note_config(CFG_POLL_IVAL, pi);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_burst();
    int unsigned n;
    logic [7:0]  v;
    n = $urandom_range(1, 16);
    case ($urandom_range(9))
      0, 1, 2: begin
        // host bytes arriving on ticks, with the odd status poll
        repeat (n + 2) begin
          if ($urandom_range(5) == 0)
            bus(OP_READ, reg_off(REG_LSR), 8'($urandom), 1'($urandom), 8'($urandom));
          else
            bus(OP_TICK, 4'($urandom), 8'($urandom), $urandom_range(3) != 0,
                8'($urandom));
        end
      end
      3, 4: begin
        repeat (n) begin
          if ($urandom_range(4) == 0)
            bus(OP_READ, reg_off(3'($urandom)), 8'($urandom), 1'($urandom),
                8'($urandom));
          else
            bus(OP_READ, reg_off(REG_RBR), 8'($urandom), 1'($urandom), 8'($urandom));
        end
      end
      5: begin
        v = 8'($urandom);
        case ($urandom_range(5))
          0: bus(OP_WRITE, reg_off(REG_IER), v, 1'($urandom), 8'($urandom));
          1: begin
            // keep the fifo on and uncleared most of the time
            v[0] = ($urandom_range(4) != 0);
            v[1] = ($urandom_range(3) == 0);
            bus(OP_WRITE, reg_off(REG_IIR), v, 1'($urandom), 8'($urandom));
          end
          2: begin
            v[7] = ($urandom_range(7) == 0);
            bus(OP_WRITE, reg_off(REG_LCR), v, 1'($urandom), 8'($urandom));
          end
          3: bus(OP_WRITE, reg_off(REG_MCR), v, 1'($urandom), 8'($urandom));
          4: begin
            bus(OP_WRITE, reg_off(REG_SCR), v, 1'($urandom), 8'($urandom));
            bus(OP_READ, reg_off(REG_SCR), 8'($urandom), 1'($urandom), 8'($urandom));
          end
          default: bus(OP_WRITE, reg_off(REG_RBR), v, 1'($urandom), 8'($urandom));
        endcase
      end
      6: begin
        v = 8'($urandom);
        v[4] = 1'b1;
        bus(OP_WRITE, reg_off(REG_MCR), v, 1'($urandom), 8'($urandom));
        repeat (n + 2) begin
          if ($urandom_range(3) == 0)
            bus(OP_TICK, 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
          else
            bus(OP_WRITE, reg_off(REG_RBR), 8'($urandom), 1'($urandom), 8'($urandom));
        end
        bus(OP_READ, reg_off(REG_LSR), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_READ, reg_off(REG_MSR), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_WRITE, reg_off(REG_MCR), 8'($urandom), 1'($urandom), 8'($urandom));
      end
      7: begin
        repeat (n) bus(OP_TICK, 4'($urandom), 8'($urandom), 1'b0, 8'($urandom));
        bus(OP_READ, reg_off(REG_IIR), 8'($urandom), 1'($urandom), 8'($urandom));
      end
      8: begin
        repeat ($urandom_range(1, 4))
          bus(2'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
      end
      default: begin
        v = 8'($urandom);
        bus(OP_WRITE, reg_off(REG_LCR), v | 8'h80, 1'($urandom), 8'($urandom));
        bus(OP_WRITE, reg_off(REG_RBR), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_WRITE, reg_off(REG_IER), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_READ, reg_off(REG_RBR), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_READ, reg_off(REG_IER), 8'($urandom), 1'($urandom), 8'($urandom));
        bus(OP_WRITE, reg_off(REG_LCR), v & 8'h7f, 1'($urandom), 8'($urandom));
      end
    endcase
  endtask

  initial begin
    int unsigned target;
    logic [CFG_DATA_W-1:0] cc, pi;
    uart_chk = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero settings: immediate timeout, poll interval acts like one
    set_timing(16'd0, 16'd0);
    bus(OP_READ, reg_off(REG_IIR), 8'h00, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_LSR), 8'h00, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_MSR), 8'h00, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_SCR), 8'hff, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_LCR), 8'h83, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_RBR), 8'ha5, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_IER), 8'h5a, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_RBR), 8'h00, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_IER), 8'h00, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_LCR), 8'h03, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_IER), 8'h0f, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_IIR), 8'hc7, 1'b0, 8'h00);
    bus(OP_TICK, 4'h0, 8'h00, 1'b1, 8'hff);
    bus(OP_READ, reg_off(REG_LSR), 8'h00, 1'b1, 8'h00);
    bus(OP_READ, reg_off(REG_IIR), 8'h00, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_RBR), 8'h00, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_RBR), 8'h00, 1'b0, 8'h00);
    // empty receive read
    bus(OP_READ, reg_off(REG_RBR), 8'h00, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_MCR), 8'h1f, 1'b0, 8'h00);
    // fifo off, then two loopback bytes overrun the single slot
    bus(OP_WRITE, reg_off(REG_IIR), 8'h06, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_RBR), 8'h3c, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_RBR), 8'hc3, 1'b0, 8'h00);
    bus(OP_READ, reg_off(REG_LSR), 8'h00, 1'b0, 8'h00);
    bus(OP_WRITE, reg_off(REG_MSR), 8'hff, 1'b1, 8'hff);
    bus(OP_READ, 4'h9, 8'h00, 1'b1, 8'h55);
    bus(OP_NONE, 4'hf, 8'hff, 1'b1, 8'haa);
    bus(OP_WRITE, reg_off(REG_MCR), 8'h00, 1'b0, 8'h00);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cc = 16'd1;     pi = 16'd1;     end
        1: begin cc = 16'd65535; pi = 16'd65535; end
        2: begin cc = 16'd2;     pi = 16'd3;     end
        3: begin cc = 16'd65535; pi = 16'd1;     end
        4: begin cc = 16'd1;     pi = 16'd2;     end
        default: begin cc = 16'd3; pi = 16'd1;   end
      endcase
      wait_drained(4);
      send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 88 : 0;
      recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 26 : 0;
      set_timing(cc, pi);
      target = items_sent + RANDOM_ITEMS / 6;
      while (items_sent < target) random_burst();
    end

    wait_drained(8);
    if (uart_chk.mismatches == 0 && uart_chk.pending_bus_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/uart_rm_pkg.sv
rtl/core/uart_rm_core.sv
rtl/core/uart_register_model_top.sv
tb/uart_register_model_top_tb.sv
